>>> hdl/hsl_pkg.sv
package hsl_pkg;

  localparam int unsigned FullTurn     = 23040;
  localparam int unsigned SixtyDeg     = 3840;
  localparam int unsigned ThirdTurn    = 7680;
  localparam int unsigned TwoThirdTurn = 15360;
  localparam int unsigned HalfTurnPlus = 11520;
  localparam int unsigned OneQ15       = 32768;
  localparam int unsigned HalfQ15      = 16384;

  localparam int unsigned DivNumW = 23;
  localparam int unsigned DivDenW = 8;
  localparam int unsigned DivQuoW = 16;

  localparam int unsigned Recip15      = 1118482;
  localparam int unsigned Recip15Shift = 24;

  localparam int unsigned NumChan = 3;

  typedef logic [7:0] chan_t;

  typedef enum logic [1:0] {
    RegHueOffset = 2'd0,
    RegSatRatio  = 2'd1,
    RegLumRatio  = 2'd2
  } reg_e;

endpackage

>>> hdl/hsl_pix_if.sv
interface hsl_in_if;
  logic                 valid;
  logic                 ready;
  hsl_pkg::chan_t       blue_in;
  hsl_pkg::chan_t       green_in;
  hsl_pkg::chan_t       red_in;

  modport source (output valid, output blue_in, output green_in, output red_in, input ready);
  modport sink   (input valid, input blue_in, input green_in, input red_in, output ready);
endinterface

interface hsl_out_if;
  logic                 valid;
  logic                 ready;
  hsl_pkg::chan_t       blue_out;
  hsl_pkg::chan_t       green_out;
  hsl_pkg::chan_t       red_out;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  input ready);
  modport sink   (input valid, input blue_out, input green_out, input red_out,
                  output ready);
endinterface

>>> hdl/hsl_div.sv
module hsl_div #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 8,
  parameter int unsigned QUO_W = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned CmpW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [CmpW-1:0]  trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = CmpW'(den_in) << (QUO_W - 1 - k);
    assign fit   = CmpW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fit ? NUM_W'(CmpW'(rem_in) - trial) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (QUO_W'(fit) << (QUO_W - 1 - k));
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

>>> hdl/hsl_hue_sat_lum_adjust_unit.sv
// HSL adjust: takes one BGR pixel per clock and returns it with the hue rotated
// and saturation and lightness scaled by the programmed ratios. A pixel passes
// through the two 16-stage restoring dividers (hue and saturation) plus the
// adjust and rebuild stages; a new pixel is accepted every cycle as long as
// the output side takes its beats. Registers
// (APB, byte address 4*i): 0 hue offset in 1/64 degree, 1 saturation ratio and
// 2 lightness ratio, both Q1.15 signed, where -1.0 leaves the value unchanged.
module hsl_hue_sat_lum_adjust_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  hsl_in_if.sink            in_if,
  hsl_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned Lat = hsl_pkg::DivQuoW;

  // configuration
  logic [14:0]        hue_off_q;
  logic signed [16:0] sat_ratio_q;
  logic signed [16:0] lum_ratio_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q   <= '0;
      sat_ratio_q <= -17'sd32768;
      lum_ratio_q <= -17'sd32768;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        hsl_pkg::RegHueOffset: hue_off_q   <= pwdata[14:0];
        hsl_pkg::RegSatRatio:  sat_ratio_q <= pwdata[16:0];
        hsl_pkg::RegLumRatio:  lum_ratio_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hsl_pkg::RegHueOffset: prdata = {17'd0, hue_off_q};
      hsl_pkg::RegSatRatio:  prdata = {{15{sat_ratio_q[16]}}, sat_ratio_q};
      hsl_pkg::RegLumRatio:  prdata = {{15{lum_ratio_q[16]}}, lum_ratio_q};
      default:               prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || out_if.ready;
  assign in_if.ready = en;

  // stage 1: max, min, dominant channel
  logic [7:0]        s0_mx, s0_mn;
  logic [2:0]        s0_base;
  logic signed [8:0] s0_delta;

  always_comb begin
    s0_mx = in_if.red_in;
    s0_mn = in_if.red_in;
    if (in_if.green_in > s0_mx) s0_mx = in_if.green_in;
    if (in_if.blue_in > s0_mx)  s0_mx = in_if.blue_in;
    if (in_if.green_in < s0_mn) s0_mn = in_if.green_in;
    if (in_if.blue_in < s0_mn)  s0_mn = in_if.blue_in;
    if (in_if.red_in == s0_mx) begin
      s0_base  = 3'd6;
      s0_delta = $signed({1'b0, in_if.green_in}) - $signed({1'b0, in_if.blue_in});
    end else if (in_if.green_in == s0_mx) begin
      s0_base  = 3'd2;
      s0_delta = $signed({1'b0, in_if.blue_in}) - $signed({1'b0, in_if.red_in});
    end else begin
      s0_base  = 3'd4;
      s0_delta = $signed({1'b0, in_if.red_in}) - $signed({1'b0, in_if.green_in});
    end
  end

  logic [7:0]        s1_mx_q, s1_mn_q;
  logic [2:0]        s1_base_q;
  logic signed [8:0] s1_delta_q;
  logic              s1_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mx_q    <= s0_mx;
      s1_mn_q    <= s0_mn;
      s1_base_q  <= s0_base;
      s1_delta_q <= s0_delta;
    end
  end

  // stage 2: sums, divider operands, lightness
  logic [8:0]                     s2_msum;
  logic [7:0]                     s2_mdiff;
  logic [7:0]                     s2_den;
  logic [hsl_pkg::DivNumW-1:0]    s2_snum;
  logic [hsl_pkg::DivNumW-1:0]    s2_hnum;
  logic [10:0]                    s2_bm;
  logic signed [12:0]             s2_k;
  logic [14:0]                    s2_y;
  logic [23:0]                    s2_yp;
  logic [15:0]                    s2_lum;

  always_comb begin
    s2_msum  = {1'b0, s1_mx_q} + {1'b0, s1_mn_q};
    s2_mdiff = s1_mx_q - s1_mn_q;
    s2_den   = (s2_msum <= 9'd255) ? s2_msum[7:0] : 8'(9'd510 - s2_msum);
    s2_snum  = {s2_mdiff, 15'd0};
    s2_bm    = 11'(s1_base_q) * 11'(s2_mdiff);
    s2_k     = $signed({2'b00, s2_bm}) + 13'(s1_delta_q);
    s2_hnum  = {s2_k[10:0], 12'd0} - 23'({s2_k[10:0], 8'd0});
    s2_y     = {s2_msum, 6'd0};
    s2_yp    = (24'(s2_y) + 24'd1) * 24'd257;
    s2_lum   = 16'(s2_y) + 16'(s2_yp[23:16]);
  end

  logic [hsl_pkg::DivQuoW-1:0] hue_q_w, sat_q_w;

  hsl_div #(
    .NUM_W (hsl_pkg::DivNumW),
    .DEN_W (hsl_pkg::DivDenW),
    .QUO_W (hsl_pkg::DivQuoW)
  ) u_div_hue (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s2_hnum),
    .den_i (s2_mdiff),
    .quo_o (hue_q_w)
  );

  hsl_div #(
    .NUM_W (hsl_pkg::DivNumW),
    .DEN_W (hsl_pkg::DivDenW),
    .QUO_W (hsl_pkg::DivQuoW)
  ) u_div_sat (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s2_snum),
    .den_i (s2_den),
    .quo_o (sat_q_w)
  );

  // side data alongside the dividers
  logic [15:0] dl_lum_q  [Lat];
  logic        dl_grey_q [Lat];
  logic        dl_vld_q  [Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) dl_vld_q[i] <= 1'b0;
    end else if (en) begin
      dl_vld_q[0] <= s1_vld_q;
      for (int i = 1; i < Lat; i++) dl_vld_q[i] <= dl_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_lum_q[0]  <= s2_lum;
      dl_grey_q[0] <= (s2_mdiff == 8'd0);
      for (int i = 1; i < Lat; i++) begin
        dl_lum_q[i]  <= dl_lum_q[i-1];
        dl_grey_q[i] <= dl_grey_q[i-1];
      end
    end
  end

  // P1: hue wrap and offset, ratio products
  logic [15:0]        a_hue, a_sx, a_lx;
  logic [16:0]        a_hsum;
  logic               a_spos, a_lpos;
  logic [16:0]        a_sqm, a_lqm, a_sb, a_lb;

  always_comb begin
    if (dl_grey_q[Lat-1]) begin
      a_hue = '0;
      a_sx  = '0;
    end else begin
      a_hue = (hue_q_w > 16'(hsl_pkg::FullTurn)) ? hue_q_w - 16'(hsl_pkg::FullTurn)
                                                 : hue_q_w;
      a_sx  = sat_q_w;
    end
    a_lx   = dl_lum_q[Lat-1];
    a_hsum = 17'(a_hue) + 17'(hue_off_q);
    a_spos = sat_ratio_q > 17'sd0;
    a_lpos = lum_ratio_q > 17'sd0;
    a_sqm  = a_spos ? 17'(sat_ratio_q) : 17'(-sat_ratio_q);
    a_lqm  = a_lpos ? 17'(lum_ratio_q) : 17'(-lum_ratio_q);
    a_sb   = a_spos ? 17'(hsl_pkg::OneQ15) - 17'(a_sx) : 17'(a_sx);
    a_lb   = a_lpos ? 17'(hsl_pkg::OneQ15) - 17'(a_lx) : 17'(a_lx);
  end

  logic [33:0] p1_sp_q, p1_lp_q;
  logic [15:0] p1_sx_q, p1_lx_q;
  logic        p1_spos_q, p1_lpos_q;
  logic [16:0] p1_hsum_q;
  logic        p1_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sp_q   <= 34'(a_sb) * 34'(a_sqm);
      p1_lp_q   <= 34'(a_lb) * 34'(a_lqm);
      p1_sx_q   <= a_sx;
      p1_lx_q   <= a_lx;
      p1_spos_q <= a_spos;
      p1_lpos_q <= a_lpos;
      p1_hsum_q <= a_hsum;
    end
  end

  // P2: finish ratio adjust
  function automatic logic [15:0] ratio_fin(input logic [15:0] x, input logic [33:0] p,
                                            input logic pos);
    logic [19:0] r;
    r = pos ? 20'(x) + 20'(p[33:15]) : 20'(p[33:15]);
    return (r > 20'(hsl_pkg::OneQ15)) ? 16'(hsl_pkg::OneQ15) : r[15:0];
  endfunction

  logic [15:0] p2_sat_q, p2_lum_q;
  logic [16:0] p2_hsum_q;
  logic        p2_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_sat_q  <= ratio_fin(p1_sx_q, p1_sp_q, p1_spos_q);
      p2_lum_q  <= ratio_fin(p1_lx_q, p1_lp_q, p1_lpos_q);
      p2_hsum_q <= p1_hsum_q;
    end
  end

  // P3: L*S product, per-channel hue wrap and ramp weight
  logic               c_grey;
  logic signed [18:0] c_h   [hsl_pkg::NumChan];
  logic [11:0]        c_t   [hsl_pkg::NumChan];
  logic signed [18:0] c_off [hsl_pkg::NumChan];

  assign c_off[0] = -19'sd7680;
  assign c_off[1] = 19'sd0;
  assign c_off[2] = 19'sd7680;

  always_comb begin
    c_grey = (p2_sat_q == 16'd0);
    for (int c = 0; c < hsl_pkg::NumChan; c++) begin
      c_h[c] = $signed({2'b00, p2_hsum_q}) + c_off[c];
      if (c_h[c] > 19'sd23040) begin
        c_h[c] = c_h[c] - 19'sd23040;
        if (c_h[c] > 19'sd23040) c_h[c] = c_h[c] - 19'sd23040;
      end else if (c_h[c] < 19'sd0) begin
        c_h[c] = c_h[c] + 19'sd23040;
      end
      if (c_grey || c_h[c] < 19'sd0) begin
        c_t[c] = '0;
      end else if (c_h[c] < 19'(hsl_pkg::SixtyDeg)) begin
        c_t[c] = c_h[c][11:0];
      end else if (c_h[c] < 19'(hsl_pkg::HalfTurnPlus)) begin
        c_t[c] = 12'(hsl_pkg::SixtyDeg);
      end else if (c_h[c] < 19'(hsl_pkg::TwoThirdTurn)) begin
        c_t[c] = 12'(19'(hsl_pkg::TwoThirdTurn) - c_h[c]);
      end else begin
        c_t[c] = '0;
      end
    end
  end

  logic [31:0] p3_ls_q;
  logic [15:0] p3_sat_q, p3_lum_q;
  logic        p3_grey_q;
  logic [11:0] p3_t_q [hsl_pkg::NumChan];
  logic        p3_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_ls_q   <= 32'(p2_sat_q) * 32'(p2_lum_q);
      p3_sat_q  <= p2_sat_q;
      p3_lum_q  <= p2_lum_q;
      p3_grey_q <= c_grey;
      for (int c = 0; c < hsl_pkg::NumChan; c++) p3_t_q[c] <= c_t[c];
    end
  end

  // P4: ramp ends
  logic [16:0] d_rm1, d_rm2, d_diff;

  always_comb begin
    if (p3_lum_q <= 16'(hsl_pkg::HalfQ15)) begin
      d_rm2 = 17'(p3_lum_q) + p3_ls_q[31:15];
    end else begin
      d_rm2 = 17'(p3_lum_q) + 17'(p3_sat_q) - p3_ls_q[31:15];
    end
    d_rm1  = {p3_lum_q, 1'b0} - d_rm2;
    d_diff = d_rm2 - d_rm1;
    if (p3_grey_q) begin
      d_rm1  = 17'(p3_lum_q);
      d_diff = '0;
    end
  end

  logic [16:0] p4_rm1_q, p4_diff_q;
  logic [11:0] p4_t_q [hsl_pkg::NumChan];
  logic        p4_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_rm1_q  <= d_rm1;
      p4_diff_q <= d_diff;
      for (int c = 0; c < hsl_pkg::NumChan; c++) p4_t_q[c] <= p3_t_q[c];
    end
  end

  // P5: slope times weight
  logic [28:0] p5_p_q [hsl_pkg::NumChan];
  logic [16:0] p5_rm1_q;
  logic        p5_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_rm1_q <= p4_rm1_q;
      for (int c = 0; c < hsl_pkg::NumChan; c++) begin
        p5_p_q[c] <= 29'(p4_diff_q) * 29'(p4_t_q[c]);
      end
    end
  end

  // P6: divide by 3840 as shift then reciprocal of 15
  logic [41:0] f_m [hsl_pkg::NumChan];

  always_comb begin
    for (int c = 0; c < hsl_pkg::NumChan; c++) begin
      f_m[c] = 42'(p5_p_q[c][28:8]) * 42'(hsl_pkg::Recip15);
    end
  end

  logic [17:0] p6_q_q [hsl_pkg::NumChan];
  logic [16:0] p6_rm1_q;
  logic        p6_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_rm1_q <= p5_rm1_q;
      for (int c = 0; c < hsl_pkg::NumChan; c++) begin
        p6_q_q[c] <= f_m[c][41:hsl_pkg::Recip15Shift];
      end
    end
  end

  // output: channel scaling and clamp
  logic [17:0]    g_v [hsl_pkg::NumChan];
  logic [25:0]    g_s [hsl_pkg::NumChan];
  hsl_pkg::chan_t g_c [hsl_pkg::NumChan];

  always_comb begin
    for (int c = 0; c < hsl_pkg::NumChan; c++) begin
      g_v[c] = 18'(p6_rm1_q) + p6_q_q[c];
      g_s[c] = {g_v[c], 8'd0} - 26'(g_v[c]);
      g_c[c] = (g_s[c][25:15] > 11'd255) ? 8'd255 : g_s[c][22:15];
    end
  end

  hsl_pkg::chan_t out_chan_q [hsl_pkg::NumChan];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < hsl_pkg::NumChan; c++) out_chan_q[c] <= g_c[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q  <= dl_vld_q[Lat-1];
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      p4_vld_q  <= p3_vld_q;
      p5_vld_q  <= p4_vld_q;
      p6_vld_q  <= p5_vld_q;
      out_vld_q <= p6_vld_q;
    end
  end

  assign out_if.valid     = out_vld_q;
  assign out_if.blue_out  = out_chan_q[0];
  assign out_if.green_out = out_chan_q[1];
  assign out_if.red_out   = out_chan_q[2];

endmodule
